/* rtl/cet_pkg.sv */
// Package for the confirmable exchange tracker: payload structs, opcode and
// message-type codes, result codes, register indexes and reset values.
// No dependencies; every other file in rtl/ uses it by scoped names.
package cet_pkg;

    // Input opcodes.
    localparam logic [1:0] OP_START    = 2'd0;
    localparam logic [1:0] OP_DATAGRAM = 2'd1;
    localparam logic [1:0] OP_TICK     = 2'd2;
    localparam logic [1:0] OP_XPORT    = 2'd3;

    // Datagram message types.
    localparam logic [1:0] TYPE_CON = 2'd0;
    localparam logic [1:0] TYPE_NON = 2'd1;
    localparam logic [1:0] TYPE_ACK = 2'd2;
    localparam logic [1:0] TYPE_RST = 2'd3;

    // Result actions.
    localparam logic [1:0] ACT_TX   = 2'd0;
    localparam logic [1:0] ACT_ACK  = 2'd1;
    localparam logic [1:0] ACT_DONE = 2'd2;

    // Finish status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_TIMEOUT = 2'd1;
    localparam logic [1:0] ST_RESET   = 2'd2;
    localparam logic [1:0] ST_XPORT   = 2'd3;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRIES = 2'd1;
    localparam int unsigned CFG_DATA_W = 24;

    localparam logic [23:0] TIMEOUT_RESET = 24'd10000;
    localparam logic [3:0]  RETRIES_RESET = 4'd3;

    // Default depth of the result queue; must be at least two.
    localparam int unsigned RESULT_DEPTH = 4;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] msg_id;
        logic [1:0]  msg_type;
        logic [7:0]  msg_code;
        logic [3:0]  tok_len;
        logic [63:0] token_value;
        logic        parse_ok;
    } item_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] ack_id;
        logic [1:0]  status;
        logic        last;
    } result_t;

    // One configuration write as seen by the core.
    typedef struct packed {
        logic                  valid;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_wr_t;

    // Zero, one or two results produced by one item.
    typedef struct packed {
        logic [1:0] cnt;
        result_t    r0;
        result_t    r1;
    } push_t;

    function automatic result_t mk_result(logic [1:0] action, logic [15:0] ack_id,
                                          logic [1:0] status, logic last);
        result_t r;
        r.action = action;
        r.ack_id = ack_id;
        r.status = status;
        r.last   = last;
        return r;
    endfunction

endpackage

/* rtl/coap_confirmable_exchange_tracker.sv */
// Top level of the confirmable exchange tracker: input register, exchange core
// and result queue. Depends on cet_pkg, cet_core and cet_result_fifo.
//
// This block follows one confirmable request from its first transmission to its
// end. A start request stores the message id and token, asks for a transmit and
// arms a deadline of retry_timeout_ticks ticks; datagram requests are matched
// against it (CON datagrams are answered with an empty ACK first), tick requests
// count the deadline down and trigger retransmissions up to max_retries times,
// and a transport error request ends the exchange. Each input request yields
// zero, one or two result requests; the final one carries last set. An accepted
// request waits in the input register while the result queue has fewer than
// two free slots; then its results are written to the result queue and m_valid
// rises as soon as the queue holds them. The block takes one input request per
// cycle for as long as the result queue has two free slots. Requests that cause
// at most one result each never fill the default queue of four against a sink
// that takes one result per cycle; requests that cause two results (a CON
// datagram that also ends the exchange) outpace such a sink, and s_ready falls
// while results back up. The configuration port is always ready; registers
// should be written only while nothing is in flight, that is with no request
// held in the input register and no result pending. Register 0 is
// retry_timeout_ticks, register 1 is max_retries; writes to other indexes are
// ignored.
module coap_confirmable_exchange_tracker #(
    parameter int unsigned ResultDepth = cet_pkg::RESULT_DEPTH
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            s_valid,
    output logic                            s_ready,
    input  cet_pkg::item_t                  s_data,

    output logic                            m_valid,
    input  logic                            m_ready,
    output cet_pkg::result_t                m_data,

    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [cet_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cet_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic             in_vld_reg;
    cet_pkg::item_t   in_data_reg;
    logic             room2;
    logic             advance;
    cet_pkg::push_t   push;
    cet_pkg::cfg_wr_t cfg_wr;

    // The held request moves on only when the queue can absorb its worst case.
    assign advance   = in_vld_reg && room2;
    assign s_ready   = !in_vld_reg || advance;
    assign cfg_ready = 1'b1;

    assign cfg_wr.valid = cfg_valid;
    assign cfg_wr.index = cfg_index;
    assign cfg_wr.data  = cfg_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    cet_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr   (cfg_wr),
        .item_vld (advance),
        .item     (in_data_reg),
        .push     (push)
    );

    cet_result_fifo #(
        .Depth (ResultDepth)
    ) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .room2   (room2),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

/* rtl/cet_core.sv */
// Exchange state and per-item decision logic of the confirmable exchange tracker.
// Depends on cet_pkg for the item, result, push and configuration types.
module cet_core (
    input  logic            aclk,
    input  logic            aresetn,
    input  cet_pkg::cfg_wr_t cfg_wr,
    input  logic            item_vld,
    input  cet_pkg::item_t  item,
    output cet_pkg::push_t  push
);

    logic [23:0] timeout_reg;
    logic [3:0]  retries_reg;

    logic        busy_reg,      busy_next;
    logic [3:0]  attempt_reg,   attempt_next;
    logic [23:0] ticks_reg,     ticks_next;
    logic        confirmed_reg, confirmed_next;
    logic [15:0] req_id_reg,    req_id_next;
    logic [63:0] req_tok_reg,   req_tok_next;
    logic [3:0]  req_tlen_reg,  req_tlen_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= cet_pkg::TIMEOUT_RESET;
            retries_reg <= cet_pkg::RETRIES_RESET;
        end else if (cfg_wr.valid) begin
            case (cfg_wr.index)
                cet_pkg::CFG_TIMEOUT: timeout_reg <= cfg_wr.data[23:0];
                cet_pkg::CFG_RETRIES: retries_reg <= cfg_wr.data[3:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            attempt_reg   <= '0;
            ticks_reg     <= '0;
            confirmed_reg <= 1'b0;
            req_id_reg    <= '0;
            req_tok_reg   <= '0;
            req_tlen_reg  <= '0;
        end else begin
            busy_reg      <= busy_next;
            attempt_reg   <= attempt_next;
            ticks_reg     <= ticks_next;
            confirmed_reg <= confirmed_next;
            req_id_reg    <= req_id_next;
            req_tok_reg   <= req_tok_next;
            req_tlen_reg  <= req_tlen_next;
        end
    end

    always_comb begin
        logic       id_match;
        logic       is_con;
        logic       fin;
        logic [1:0] fin_st;

        busy_next      = busy_reg;
        attempt_next   = attempt_reg;
        ticks_next     = ticks_reg;
        confirmed_next = confirmed_reg;
        req_id_next    = req_id_reg;
        req_tok_next   = req_tok_reg;
        req_tlen_next  = req_tlen_reg;
        push           = '0;

        id_match = (item.msg_id == req_id_reg);
        is_con   = (item.msg_type == cet_pkg::TYPE_CON);
        fin      = 1'b0;
        fin_st   = cet_pkg::ST_OK;

        if (item_vld) begin
            case (item.opcode)
                cet_pkg::OP_START: begin
                    // A start always wins, even over a running exchange.
                    busy_next      = 1'b1;
                    attempt_next   = '0;
                    confirmed_next = 1'b0;
                    ticks_next     = timeout_reg;
                    req_id_next    = item.msg_id;
                    req_tok_next   = item.token_value;
                    req_tlen_next  = item.tok_len;
                    push.cnt       = 2'd1;
                    push.r0        = cet_pkg::mk_result(cet_pkg::ACT_TX, '0,
                                                        cet_pkg::ST_OK, 1'b1);
                end
                cet_pkg::OP_DATAGRAM: begin
                    if (busy_reg && item.parse_ok) begin
                        if (item.msg_type == cet_pkg::TYPE_RST) begin
                            if (id_match) begin
                                fin    = 1'b1;
                                fin_st = cet_pkg::ST_RESET;
                            end
                        end else if (item.msg_type == cet_pkg::TYPE_ACK &&
                                     item.msg_code == 8'd0) begin
                            if (id_match) begin
                                confirmed_next = 1'b1;
                            end
                        end else if (item.msg_type == cet_pkg::TYPE_ACK && !id_match) begin
                            fin = 1'b0;
                        end else if (item.tok_len == req_tlen_reg &&
                                     item.token_value == req_tok_reg) begin
                            fin    = 1'b1;
                            fin_st = cet_pkg::ST_OK;
                        end

                        if (fin) begin
                            busy_next = 1'b0;
                        end

                        // A CON datagram is acknowledged before any finish result.
                        if (is_con && fin) begin
                            push.cnt = 2'd2;
                            push.r0  = cet_pkg::mk_result(cet_pkg::ACT_ACK, item.msg_id,
                                                          cet_pkg::ST_OK, 1'b0);
                            push.r1  = cet_pkg::mk_result(cet_pkg::ACT_DONE, '0,
                                                          fin_st, 1'b1);
                        end else if (is_con) begin
                            push.cnt = 2'd1;
                            push.r0  = cet_pkg::mk_result(cet_pkg::ACT_ACK, item.msg_id,
                                                          cet_pkg::ST_OK, 1'b1);
                        end else if (fin) begin
                            push.cnt = 2'd1;
                            push.r0  = cet_pkg::mk_result(cet_pkg::ACT_DONE, '0,
                                                          fin_st, 1'b1);
                        end
                    end
                end
                cet_pkg::OP_TICK: begin
                    if (busy_reg) begin
                        if (ticks_reg > 24'd1) begin
                            ticks_next = ticks_reg - 24'd1;
                        end else if (confirmed_reg || attempt_reg >= retries_reg) begin
                            ticks_next = '0;
                            busy_next  = 1'b0;
                            push.cnt   = 2'd1;
                            push.r0    = cet_pkg::mk_result(cet_pkg::ACT_DONE, '0,
                                                            cet_pkg::ST_TIMEOUT, 1'b1);
                        end else begin
                            attempt_next = attempt_reg + 4'd1;
                            ticks_next   = timeout_reg;
                            push.cnt     = 2'd1;
                            push.r0      = cet_pkg::mk_result(cet_pkg::ACT_TX, '0,
                                                              cet_pkg::ST_OK, 1'b1);
                        end
                    end
                end
                default: begin
                    if (busy_reg) begin
                        busy_next = 1'b0;
                        push.cnt  = 2'd1;
                        push.r0   = cet_pkg::mk_result(cet_pkg::ACT_DONE, '0,
                                                       cet_pkg::ST_XPORT, 1'b1);
                    end
                end
            endcase
        end
    end

endmodule

/* rtl/cet_result_fifo.sv */
// Result queue of the confirmable exchange tracker: takes up to two results per
// cycle, hands one out per ready cycle; uses cet_pkg for result and push types.
module cet_result_fifo #(
    parameter int unsigned Depth = cet_pkg::RESULT_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  cet_pkg::push_t    push,
    output logic              room2,
    output logic              m_valid,
    input  logic              m_ready,
    output cet_pkg::result_t  m_data
);

    localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned CntW = $clog2(Depth + 1);

    cet_pkg::result_t mem [Depth];

    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg,  count_next;
    logic [PtrW-1:0] wr_ptr_inc;
    logic            pop;

    function automatic logic [PtrW-1:0] ptr_inc(logic [PtrW-1:0] p);
        return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
    endfunction

    assign pop        = m_valid && m_ready;
    assign m_valid    = (count_reg != '0);
    assign m_data     = mem[rd_ptr_reg];
    assign room2      = (count_reg <= CntW'(Depth - 2));
    assign wr_ptr_inc = ptr_inc(wr_ptr_reg);

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        case (push.cnt)
            2'd1:    wr_ptr_next = wr_ptr_inc;
            2'd2:    wr_ptr_next = ptr_inc(wr_ptr_inc);
            default: wr_ptr_next = wr_ptr_reg;
        endcase
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CntW'(push.cnt) - CntW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.cnt != 2'd0) begin
            mem[wr_ptr_reg] <= push.r0;
        end
        if (push.cnt == 2'd2) begin
            mem[wr_ptr_inc] <= push.r1;
        end
    end

endmodule

/* rtl/cet_checker.sv */
// Port-level checks for the confirmable exchange tracker, bound to the top level.
// Depends on cet_pkg for the result type and action codes.
module cet_checker (
    input logic             aclk,
    input logic             aresetn,
    input logic             m_valid,
    input logic             m_ready,
    input cet_pkg::result_t m_data,
    input logic             cfg_valid,
    input logic             cfg_ready
);

    // A stalled result must not change or vanish.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // Only empty-ACK results carry a message id.
    a_ack_id: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.action != cet_pkg::ACT_ACK |-> m_data.ack_id == 16'd0)
        else $error("ack_id set on a non-ACK result");

    // A transmit request is always the only result of its input.
    a_tx_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.action == cet_pkg::ACT_TX |-> m_data.last)
        else $error("transmit result without last");

    // Reset empties the result queue.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result pending after reset");

    // Configuration writes are never back-pressured.
    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |-> cfg_ready)
        else $error("configuration write stalled");

endmodule

bind coap_confirmable_exchange_tracker cet_checker u_cet_checker (.*);

/* test/cet_exchange_checker.sv */
// Result checker for the confirmable exchange tracker: follows every accepted
// request, predicts the results it must cause and compares them in order.
// Depends on cet_pkg for the payload structs and the code constants.
module cet_exchange_checker (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            s_valid,
    input  logic                            s_ready,
    input  cet_pkg::item_t                  s_data,

    input  logic                            m_valid,
    input  logic                            m_ready,
    input  cet_pkg::result_t                m_data,

    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [cet_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cet_pkg::CFG_DATA_W-1:0]  cfg_data,

    output int                              errors,
    output int                              outstanding,
    output int                              checked
);

    // Shadow copy of the registers and of the exchange state.
    logic [23:0] cfg_timeout;
    logic [3:0]  cfg_retries;
    logic        xchg_open;
    logic [3:0]  resends;
    logic [23:0] deadline_cnt;
    logic        acked;
    logic [15:0] req_mid;
    logic [63:0] req_tok;
    logic [3:0]  req_tok_len;

    cet_pkg::result_t due_results[$];
    cet_pkg::result_t step_out[2];
    int               n_out;
    int               err_cnt = 0;
    int               chk_cnt = 0;

    task automatic add_result(logic [1:0] act, logic [15:0] mid, logic [1:0] st);
        cet_pkg::result_t r;
        r.action = act;
        r.ack_id = mid;
        r.status = st;
        r.last   = 1'b0;
        step_out[n_out] = r;
        n_out++;
    endtask

    task automatic close_exchange(logic [1:0] st);
        xchg_open = 1'b0;
        add_result(cet_pkg::ACT_DONE, 16'd0, st);
    endtask

    task automatic predict_exchange(cet_pkg::item_t it);
        cet_pkg::result_t r;
        n_out = 0;
        case (it.opcode)
            cet_pkg::OP_START: begin
                xchg_open    = 1'b1;
                resends      = 4'd0;
                acked        = 1'b0;
                deadline_cnt = cfg_timeout;
                req_mid      = it.msg_id;
                req_tok      = it.token_value;
                req_tok_len  = it.tok_len;
                add_result(cet_pkg::ACT_TX, 16'd0, cet_pkg::ST_OK);
            end
            cet_pkg::OP_DATAGRAM: begin
                if (xchg_open && it.parse_ok) begin
                    if (it.msg_type == cet_pkg::TYPE_CON)
                        add_result(cet_pkg::ACT_ACK, it.msg_id, cet_pkg::ST_OK);
                    if (it.msg_type == cet_pkg::TYPE_RST) begin
                        if (it.msg_id == req_mid)
                            close_exchange(cet_pkg::ST_RESET);
                    end else if (it.msg_type == cet_pkg::TYPE_ACK && it.msg_code == 8'd0) begin
                        if (it.msg_id == req_mid)
                            acked = 1'b1;
                    end else if (it.msg_type == cet_pkg::TYPE_ACK && it.msg_id != req_mid) begin
                        // A piggybacked response to some other request is dropped.
                    end else if (it.tok_len == req_tok_len && it.token_value == req_tok) begin
                        close_exchange(cet_pkg::ST_OK);
                    end
                end
            end
            cet_pkg::OP_TICK: begin
                if (xchg_open) begin
                    if (deadline_cnt > 24'd1) begin
                        deadline_cnt = deadline_cnt - 24'd1;
                    end else begin
                        deadline_cnt = 24'd0;
                        if (acked || resends >= cfg_retries) begin
                            close_exchange(cet_pkg::ST_TIMEOUT);
                        end else begin
                            resends      = resends + 4'd1;
                            deadline_cnt = cfg_timeout;
                            add_result(cet_pkg::ACT_TX, 16'd0, cet_pkg::ST_OK);
                        end
                    end
                end
            end
            cet_pkg::OP_XPORT: begin
                if (xchg_open)
                    close_exchange(cet_pkg::ST_XPORT);
            end
            default: ;
        endcase
        for (int i = 0; i < n_out; i++) begin
            r = step_out[i];
            r.last = (i == n_out - 1);
            due_results.push_back(r);
        end
    endtask

    task automatic field_mismatch(string fname, logic [15:0] want, logic [15:0] got);
        $display("%0t: %s mismatch, expected %h, got %h", $time, fname, want, got);
        err_cnt++;
    endtask

    task automatic check_result(cet_pkg::result_t got);
        cet_pkg::result_t want;
        if (due_results.size() == 0) begin
            $display("%0t: result with nothing expected: action %0d ack_id %h status %0d last %0b",
                     $time, got.action, got.ack_id, got.status, got.last);
            err_cnt++;
        end else begin
            want = due_results.pop_front();
            chk_cnt++;
            if (got.action !== want.action)
                field_mismatch("action", 16'(want.action), 16'(got.action));
            if (got.ack_id !== want.ack_id)
                field_mismatch("ack_id", want.ack_id, got.ack_id);
            if (got.status !== want.status)
                field_mismatch("status", 16'(want.status), 16'(got.status));
            if (got.last !== want.last)
                field_mismatch("last", 16'(want.last), 16'(got.last));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            cfg_timeout  = cet_pkg::TIMEOUT_RESET;
            cfg_retries  = cet_pkg::RETRIES_RESET;
            xchg_open    = 1'b0;
            resends      = 4'd0;
            deadline_cnt = 24'd0;
            acked        = 1'b0;
            req_mid      = 16'd0;
            req_tok      = 64'd0;
            req_tok_len  = 4'd0;
            due_results.delete();
        end else begin
            if (m_valid && m_ready)
                check_result(m_data);
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == cet_pkg::CFG_TIMEOUT)
                    cfg_timeout = cfg_data;
                else if (cfg_index == cet_pkg::CFG_RETRIES)
                    cfg_retries = cfg_data[3:0];
            end
            if (s_valid && s_ready)
                predict_exchange(s_data);
        end
        errors      <= err_cnt;
        checked     <= chk_cnt;
        outstanding <= due_results.size();
    end

endmodule

/* test/coap_confirmable_exchange_tracker_tb.sv */
// Testbench top for the confirmable exchange tracker: clock, reset, request
// stimulus, result sink and verdict. Depends on cet_pkg, the tracker RTL and
// cet_exchange_checker, which does all prediction and comparison.
module coap_confirmable_exchange_tracker_tb;

    // Register index that the block does not decode; writes to it must be ignored.
    localparam logic [cet_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    // Cycles to let pass once nothing is expected: a request that causes no result
    // can still sit in the input register.
    localparam int SETTLE = 6;
    // Cycles without any handshake after which the run is declared hung.
    localparam int QUIET_LIMIT = 2000;
    // Length of the deliberate receiver hold-off.
    localparam int HOLD_CYCLES = 300;

    logic                           aclk;
    logic                           aresetn;
    logic                           s_valid;
    logic                           s_ready;
    cet_pkg::item_t                 s_data;
    logic                           m_valid;
    logic                           m_ready;
    cet_pkg::result_t               m_data;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [cet_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [cet_pkg::CFG_DATA_W-1:0] cfg_data;

    int errors;
    int outstanding;
    int checked;

    // Stimulus shaping shared between the sender and the sink process.
    bit src_steady  = 1'b0;
    bit sink_steady = 1'b0;
    int sink_hold   = 0;

    // Register values currently programmed, used only to shape stimulus.
    logic [23:0] tmo_now = cet_pkg::TIMEOUT_RESET;
    logic [3:0]  rtr_now = cet_pkg::RETRIES_RESET;

    int n_start    = 0;
    int n_dgram    = 0;
    int n_tick     = 0;
    int n_xport    = 0;
    int n_settings = 0;
    int quiet      = 0;

    coap_confirmable_exchange_tracker u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    cet_exchange_checker u_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .errors      (errors),
        .outstanding (outstanding),
        .checked     (checked)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Idle length for either side: mostly none, often short, now and then long.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // A well-formed token: the low len bytes carry data, the unused bytes are zero.
    function automatic logic [63:0] rand_token(logic [3:0] len);
        logic [63:0] v;
        v = {$urandom, $urandom};
        if (len >= 4'd8)
            return v;
        return v & ((64'd1 << (8 * len)) - 64'd1);
    endfunction

    // Every field random within its range; callers override what matters.
    function automatic cet_pkg::item_t rand_item();
        cet_pkg::item_t it;
        it.opcode      = 2'($urandom_range(0, 3));
        it.msg_id      = 16'($urandom);
        it.msg_type    = 2'($urandom_range(0, 3));
        it.msg_code    = 8'($urandom);
        it.tok_len     = 4'($urandom_range(0, 8));
        it.token_value = {$urandom, $urandom};
        it.parse_ok    = 1'($urandom_range(0, 1));
        return it;
    endfunction

    function automatic cet_pkg::item_t mk_start(logic [15:0] id, logic [3:0] len,
                                                logic [63:0] tok);
        cet_pkg::item_t it;
        it             = rand_item();
        it.opcode      = cet_pkg::OP_START;
        it.msg_id      = id;
        it.tok_len     = len;
        it.token_value = tok;
        return it;
    endfunction

    function automatic cet_pkg::item_t mk_dgram(logic [1:0] typ, logic [15:0] id,
                                                logic [7:0] code, logic [3:0] len,
                                                logic [63:0] tok, logic ok);
        cet_pkg::item_t it;
        it.opcode      = cet_pkg::OP_DATAGRAM;
        it.msg_id      = id;
        it.msg_type    = typ;
        it.msg_code    = code;
        it.tok_len     = len;
        it.token_value = tok;
        it.parse_ok    = ok;
        return it;
    endfunction

    function automatic cet_pkg::item_t mk_op(logic [1:0] op);
        cet_pkg::item_t it;
        it        = rand_item();
        it.opcode = op;
        return it;
    endfunction

    // Offers one request and holds it until accepted, then idles for a random gap.
    // With no gap valid simply stays high for the next request.
    task automatic send_item(cet_pkg::item_t it);
        int gap;
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        case (it.opcode)
            cet_pkg::OP_START:    n_start++;
            cet_pkg::OP_DATAGRAM: n_dgram++;
            cet_pkg::OP_TICK:     n_tick++;
            cet_pkg::OP_XPORT:    n_xport++;
            default: ;
        endcase
        gap = src_steady ? 0 : idle_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Stops offering requests and waits until every predicted result has come back.
    // The first edge lets the checker count the request accepted last.
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // Programs both registers back to back on an idle block, plus a write to an
    // undecoded index that must leave everything unchanged.
    task automatic write_regs(logic [23:0] tmo, logic [3:0] rtr);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= cet_pkg::CFG_TIMEOUT;
        cfg_data  <= tmo;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_index <= cet_pkg::CFG_RETRIES;
        cfg_data  <= {20'($urandom), rtr};
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_index <= CFG_SPARE;
        cfg_data  <= 24'($urandom);
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid <= 1'b0;
        tmo_now = tmo;
        rtr_now = rtr;
        n_settings++;
    endtask

    // Random exchanges: mostly a start followed by ticks and datagrams that relate
    // to it, so deadlines, retransmissions and all endings are reached. A loose
    // shadow of whether the exchange is still open steers when to start anew;
    // requests sent while it is closed are noise and do not count.
    task automatic run_exchanges(int n_items);
        cet_pkg::item_t it;
        int             done_items;
        int             r;
        int             budget;
        int             ticks;
        bit             in_xchg;
        logic [15:0]    cur_id;
        logic [63:0]    cur_tok;
        logic [3:0]     cur_len;
        done_items = 0;
        in_xchg    = 1'b0;
        ticks      = 0;
        cur_id     = 16'($urandom);
        cur_len    = 4'd0;
        cur_tok    = 64'd0;
        budget     = (tmo_now == 24'd0 ? 1 : int'(tmo_now)) * (int'(rtr_now) + 1);
        while (done_items < n_items) begin
            r = $urandom_range(0, 99);
            if (!in_xchg) begin
                if (r < 80) begin
                    if ($urandom_range(0, 4) != 0)
                        cur_id = 16'($urandom);
                    cur_len = 4'($urandom_range(0, 8));
                    cur_tok = rand_token(cur_len);
                    it      = mk_start(cur_id, cur_len, cur_tok);
                    in_xchg = 1'b1;
                    ticks   = 0;
                    done_items++;
                end else begin
                    it = rand_item();
                end
            end else begin
                done_items++;
                it = mk_dgram(cet_pkg::TYPE_NON, cur_id, 8'($urandom_range(1, 255)), cur_len,
                              cur_tok, 1'b1);
                if (r < 60) begin
                    it = mk_op(cet_pkg::OP_TICK);
                    ticks++;
                    if (ticks >= budget)
                        in_xchg = 1'b0;
                end else if (r < 68) begin
                    // Empty ACK, usually for our request.
                    it.msg_type    = cet_pkg::TYPE_ACK;
                    it.msg_code    = 8'd0;
                    it.tok_len     = 4'($urandom_range(0, 8));
                    it.token_value = rand_token(it.tok_len);
                    if ($urandom_range(0, 9) < 3)
                        it.msg_id = 16'($urandom);
                end else if (r < 75) begin
                    // A CON request from the peer that is not our response.
                    it.msg_type    = cet_pkg::TYPE_CON;
                    it.msg_id      = 16'($urandom);
                    it.msg_code    = 8'($urandom);
                    it.tok_len     = 4'($urandom_range(0, 8));
                    it.token_value = rand_token(it.tok_len);
                end else if (r < 82) begin
                    // Our response, separate or piggybacked.
                    if ($urandom_range(0, 1) != 0)
                        it.msg_type = cet_pkg::TYPE_NON;
                    else if ($urandom_range(0, 1) != 0)
                        it.msg_type = cet_pkg::TYPE_CON;
                    else
                        it.msg_type = cet_pkg::TYPE_ACK;
                    if (it.msg_type != cet_pkg::TYPE_ACK || $urandom_range(0, 4) == 0)
                        it.msg_id = 16'($urandom);
                    in_xchg = !(it.msg_type == cet_pkg::TYPE_ACK && it.msg_id != cur_id);
                end else if (r < 85) begin
                    it.msg_type = cet_pkg::TYPE_RST;
                    it.msg_code = 8'($urandom);
                    if ($urandom_range(0, 9) < 4)
                        it.msg_id = 16'($urandom);
                    if (it.msg_id == cur_id)
                        in_xchg = 1'b0;
                end else if (r < 89) begin
                    // Foreign token on a non-confirmable or piggybacked datagram.
                    it.msg_type    = ($urandom_range(0, 1) != 0) ? cet_pkg::TYPE_NON
                                                                 : cet_pkg::TYPE_ACK;
                    it.tok_len     = 4'($urandom_range(0, 8));
                    it.token_value = rand_token(it.tok_len);
                    if ($urandom_range(0, 1) != 0)
                        it.msg_id = 16'($urandom);
                end else if (r < 93) begin
                    // Malformed, sometimes carrying our id and token.
                    if ($urandom_range(0, 1) != 0)
                        it = rand_item();
                    it.opcode   = cet_pkg::OP_DATAGRAM;
                    it.parse_ok = 1'b0;
                end else if (r < 95) begin
                    it      = mk_op(cet_pkg::OP_XPORT);
                    in_xchg = 1'b0;
                end else if (r < 97) begin
                    // A new start drops the running exchange.
                    cur_id  = 16'($urandom);
                    cur_len = 4'($urandom_range(0, 8));
                    cur_tok = rand_token(cur_len);
                    it      = mk_start(cur_id, cur_len, cur_tok);
                    ticks   = 0;
                end else begin
                    it = rand_item();
                end
            end
            send_item(it);
        end
    endtask

    // Receiver: random stalls and runs of ready, a steady mode, and on request
    // one long hold-off that it counts itself.
    initial begin : sink
        int stall;
        int run;
        m_ready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (sink_hold > 0) begin
                stall     = sink_hold;
                sink_hold = 0;
            end else if (sink_steady) begin
                stall = 0;
            end else begin
                stall = idle_len();
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            run = sink_steady ? 16 : $urandom_range(1, 8);
            repeat (run) @(posedge aclk);
        end
    end

    // Watchdog: a run with no handshake on any channel for too long is hung.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("coap_confirmable_exchange_tracker_tb: errors");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    initial begin : stimulus
        cet_pkg::item_t it;
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= cet_pkg::CFG_TIMEOUT;
        cfg_data  <= '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part, first under the reset register values.
        // Requests to an idle block are ignored, a CON datagram too.
        send_item(mk_op(cet_pkg::OP_TICK));
        send_item(mk_dgram(cet_pkg::TYPE_CON, 16'h0042, 8'h01, 4'd0, 64'd0, 1'b1));
        send_item(mk_op(cet_pkg::OP_XPORT));
        // Largest id and a full eight-byte token of all ones.
        send_item(mk_start(16'hFFFF, 4'd8, '1));
        // A malformed datagram changes nothing, even if it would match.
        send_item(mk_dgram(cet_pkg::TYPE_CON, 16'hFFFF, 8'h45, 4'd8, '1, 1'b0));
        // A CON with a foreign token only gets its empty ACK.
        send_item(mk_dgram(cet_pkg::TYPE_CON, 16'h1234, 8'h00, 4'd8, 64'd1, 1'b1));
        // An empty ACK for our id marks the request confirmed.
        send_item(mk_dgram(cet_pkg::TYPE_ACK, 16'hFFFF, 8'h00, 4'd0, 64'd0, 1'b1));
        // A piggybacked ACK with a foreign id is dropped although the token matches.
        send_item(mk_dgram(cet_pkg::TYPE_ACK, 16'h0000, 8'h45, 4'd8, '1, 1'b1));
        // A NON response with the highest code and our token ends with success.
        send_item(mk_dgram(cet_pkg::TYPE_NON, 16'h0000, 8'hFF, 4'd8, '1, 1'b1));
        // Zero id and an empty token.
        send_item(mk_start(16'h0000, 4'd0, 64'd0));
        send_item(mk_dgram(cet_pkg::TYPE_RST, 16'h0001, 8'h00, 4'd0, 64'd0, 1'b1));
        // Our id on a piggybacked ACK but a different token: nothing happens.
        send_item(mk_dgram(cet_pkg::TYPE_ACK, 16'h0000, 8'h44, 4'd1, 64'h7, 1'b1));
        send_item(mk_dgram(cet_pkg::TYPE_RST, 16'h0000, 8'h00, 4'd0, 64'd0, 1'b1));
        // A start while busy silently replaces the running exchange.
        send_item(mk_start(16'h5A5A, 4'd4, 64'hDEAD_BEEF));
        send_item(mk_start(16'hA5A5, 4'd2, 64'hBEEF));
        // A CON carrying our token: empty ACK first, then success.
        send_item(mk_dgram(cet_pkg::TYPE_CON, 16'h7777, 8'h45, 4'd2, 64'hBEEF, 1'b1));
        // Tokens differing only in an unused byte do not match.
        send_item(mk_start(16'h0101, 4'd1, 64'h80));
        send_item(mk_dgram(cet_pkg::TYPE_NON, 16'h0101, 8'h45, 4'd1, 64'h180, 1'b1));
        send_item(mk_op(cet_pkg::OP_XPORT));

        // A zero timeout behaves as one tick; no retries allowed.
        write_regs(24'd0, 4'd0);
        send_item(mk_start(16'h0202, 4'd3, 64'h00AB_CDEF));
        send_item(mk_op(cet_pkg::OP_TICK));

        // A confirmed request times out at its deadline without retransmitting.
        write_regs(24'd2, 4'd1);
        send_item(mk_start(16'h0303, 4'd0, 64'd0));
        send_item(mk_dgram(cet_pkg::TYPE_ACK, 16'h0303, 8'h00, 4'd0, 64'd0, 1'b1));
        send_item(mk_op(cet_pkg::OP_TICK));
        send_item(mk_op(cet_pkg::OP_TICK));

        // Random part over several register settings.
        write_regs(24'd1, 4'd0);
        run_exchanges(60);

        // A stretch with no idling on either side.
        write_regs(24'd3, 4'd2);
        src_steady  = 1'b1;
        sink_steady = 1'b1;
        run_exchanges(80);
        src_steady  = 1'b0;
        sink_steady = 1'b0;

        write_regs(24'd2, 4'd15);
        run_exchanges(80);

        // Receiver holds off for a long stretch while requests keep coming, so the
        // result queue fills and the block stops taking requests.
        write_regs(24'd4, 4'd1);
        sink_hold = HOLD_CYCLES;
        while (sink_hold != 0)
            @(posedge aclk);
        src_steady = 1'b1;
        send_item(mk_start(16'($urandom), 4'd2, rand_token(4'd2)));
        repeat (40) begin
            if ($urandom_range(0, 1) != 0)
                it = mk_start(16'($urandom), 4'd2, rand_token(4'd2));
            else
                it = mk_dgram(cet_pkg::TYPE_CON, 16'($urandom), 8'($urandom), 4'd1, 64'd5,
                              1'b1);
            send_item(it);
        end
        src_steady = 1'b0;

        // Largest timeout and most retries: deadlines never come within reach.
        write_regs(24'hFF_FFFF, 4'd15);
        run_exchanges(40);

        write_regs(24'd5, 4'd3);
        run_exchanges(80);

        write_regs(24'd1, 4'd15);
        run_exchanges(80);

        wait_drained();
        $display("run covered %0d requests: %0d start, %0d datagram, %0d tick, %0d error",
                 n_start + n_dgram + n_tick + n_xport, n_start, n_dgram, n_tick, n_xport);
        $display("%0d results checked across %0d register settings, with a receiver hold-off",
                 checked, n_settings);
        if (errors == 0)
            $display("coap_confirmable_exchange_tracker_tb: clean");
        else
            $display("coap_confirmable_exchange_tracker_tb: errors");
        $finish;
    end

endmodule

/* coap_confirmable_exchange_tracker.f */
rtl/cet_pkg.sv
rtl/cet_core.sv
rtl/cet_result_fifo.sv
rtl/coap_confirmable_exchange_tracker.sv
rtl/cet_checker.sv
test/cet_exchange_checker.sv
test/coap_confirmable_exchange_tracker_tb.sv
